// ===== hdl/fsp_pkg.sv =====
// ----------------------------------------------------------------------------
// fsp_pkg
// shared types and constants of the framed packet sender
// ----------------------------------------------------------------------------
package fsp_pkg;

  // payload store depth
  localparam int PAYLOAD_SIZE = 128;
  localparam int ADDR_W = (PAYLOAD_SIZE > 1) ? $clog2(PAYLOAD_SIZE) : 1;

  // frame layout: 2 start delimiters, number (2), total (1), payload, crc (4), 2 end delimiters
  localparam int POS_W = 8;
  localparam int FRAME_LEN = PAYLOAD_SIZE + 11;
  localparam logic [POS_W-1:0] POS_SD0 = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SD1 = POS_W'(1);
  localparam logic [POS_W-1:0] POS_NUM_LO = POS_W'(2);
  localparam logic [POS_W-1:0] POS_NUM_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_TOTAL = POS_W'(4);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(5);
  localparam logic [POS_W-1:0] POS_CRC = POS_W'(5 + PAYLOAD_SIZE);
  localparam logic [POS_W-1:0] POS_ED0 = POS_W'(9 + PAYLOAD_SIZE);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LEN - 1);

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DELIMS = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ACK = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_NACK = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_STOP = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_ATT = 3'd5;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [7:0] MAX_ATT_RESET = 8'd3;

  // request kinds, encoded as on the input tuser
  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_RX    = 2'd2,
    REQ_TICK  = 2'd3
  } req_kind_t;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_ACKED     = 2'd1,
    ST_EXHAUSTED = 2'd2,
    ST_STOPPED   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  // classified request handed from front to back
  typedef struct packed {
    req_kind_t   kind;
    logic        idx_ok;
    logic [7:0]  data_byte;
    logic [6:0]  payload_index;
    logic [15:0] packet_number;
    logic [7:0]  total_packets;
    logic [31:0] packet_crc;
  } req_t;

endpackage

// ===== hdl/fsp_front.sv =====
// ----------------------------------------------------------------------------
// fsp_front
// accepts requests, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module fsp_front
  import fsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  output logic        req_valid,
  output req_t        req,
  input  logic        req_pop
);

  req_t       entries_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  req_t       incoming;
  logic       push;

  always_comb begin
    incoming.kind          = req_kind_t'(in_tuser);
    incoming.data_byte     = in_tdata[7:0];
    incoming.payload_index = in_tdata[14:8];
    incoming.packet_number = in_tdata[30:15];
    incoming.total_packets = in_tdata[38:31];
    incoming.packet_crc    = in_tdata[70:39];
    // loads beyond the store are dropped
    incoming.idx_ok        = (int'(in_tdata[14:8]) < PAYLOAD_SIZE);
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign req_valid = (count_r != 2'd0);
  assign req       = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = req_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(req_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= incoming;
    end
  end

endmodule

// ===== hdl/fsp_back.sv =====
// ----------------------------------------------------------------------------
// fsp_back
// protocol engine: payload store, frame sequencing, response handling
// ----------------------------------------------------------------------------
module fsp_back
  import fsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  req_t                  req,
  output logic                  req_pop,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata
);

  // configuration
  logic [31:0] delims_r, timeout_r;
  logic [7:0]  ack_r, nack_r, stop_r, max_att_r;

  // protocol state
  phase_t      phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]  att_r, att_nxt;
  logic [31:0] timer_r, timer_nxt;
  logic [15:0] num_r, num_nxt;
  logic [7:0]  total_r, total_nxt;
  logic [31:0] crc_r, crc_nxt;

  // payload store
  logic [7:0]  mem [PAYLOAD_SIZE];
  logic [7:0]  mem_rd_r;
  logic        mem_we, mem_re;
  logic [ADDR_W-1:0] mem_wa, mem_ra;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_mem_r, out_mem_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_txv_r, out_txv_nxt;
  status_t     out_st_r, out_st_nxt;
  logic [7:0]  out_att_r, out_att_nxt;

  logic        fire, retry;
  logic [31:0] timer_inc;
  logic [1:0]  crc_sel;
  logic [POS_W-1:0] pos_inc;

  assign fire    = req_valid && (!out_valid_r || out_tready);
  assign req_pop = fire;
  assign mem_wa  = ADDR_W'(req.payload_index);
  assign mem_ra  = ADDR_W'(pos_r - POS_PAYLOAD);
  assign crc_sel = 2'(pos_r - POS_CRC);
  assign pos_inc = pos_r + POS_W'(1);
  assign timer_inc = (timer_r == 32'hFFFF_FFFF) ? timer_r : timer_r + 32'd1;

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    att_nxt       = att_r;
    timer_nxt     = timer_r;
    num_nxt       = num_r;
    total_nxt     = total_r;
    crc_nxt       = crc_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    retry         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mem_nxt   = out_mem_r;
    out_byte_nxt  = out_byte_r;
    out_txv_nxt   = out_txv_r;
    out_st_nxt    = out_st_r;
    out_att_nxt   = out_att_r;
    if (fire) begin
      case (req.kind)
        REQ_LOAD: begin
          mem_we = (phase_r == PH_IDLE) && req.idx_ok;
        end
        REQ_START: begin
          if (phase_r == PH_IDLE) begin
            num_nxt   = req.packet_number;
            total_nxt = req.total_packets;
            crc_nxt   = req.packet_crc;
            att_nxt   = 8'd1;
            pos_nxt   = '0;
            timer_nxt = '0;
            phase_nxt = PH_SEND;
          end
        end
        REQ_RX: begin
          if (phase_r == PH_WAIT) begin
            if (req.data_byte == ack_r) begin
              phase_nxt     = PH_IDLE;
              out_valid_nxt = 1'b1;
              out_mem_nxt   = 1'b0;
              out_byte_nxt  = 8'd0;
              out_txv_nxt   = 1'b0;
              out_st_nxt    = ST_ACKED;
              out_att_nxt   = att_r;
            end else if (req.data_byte == nack_r) begin
              retry = 1'b1;
            end else if (req.data_byte == stop_r) begin
              phase_nxt     = PH_IDLE;
              out_valid_nxt = 1'b1;
              out_mem_nxt   = 1'b0;
              out_byte_nxt  = 8'd0;
              out_txv_nxt   = 1'b0;
              out_st_nxt    = ST_STOPPED;
              out_att_nxt   = att_r;
            end
          end
        end
        REQ_TICK: begin
          if (phase_r == PH_SEND) begin
            out_valid_nxt = 1'b1;
            out_mem_nxt   = 1'b0;
            out_txv_nxt   = 1'b1;
            out_st_nxt    = ST_NONE;
            out_att_nxt   = att_r;
            if (pos_r == POS_SD0) begin
              out_byte_nxt = delims_r[7:0];
            end else if (pos_r == POS_SD1) begin
              out_byte_nxt = delims_r[15:8];
            end else if (pos_r == POS_NUM_LO) begin
              out_byte_nxt = num_r[7:0];
            end else if (pos_r == POS_NUM_HI) begin
              out_byte_nxt = num_r[15:8];
            end else if (pos_r == POS_TOTAL) begin
              out_byte_nxt = total_r;
            end else if (pos_r < POS_CRC) begin
              mem_re      = 1'b1;
              out_mem_nxt = 1'b1;
            end else if (pos_r < POS_ED0) begin
              out_byte_nxt = crc_r[{crc_sel, 3'b000} +: 8];
            end else if (pos_r == POS_ED0) begin
              out_byte_nxt = delims_r[23:16];
            end else begin
              out_byte_nxt = delims_r[31:24];
            end
            if (pos_r >= POS_LAST) begin
              pos_nxt   = '0;
              timer_nxt = '0;
              phase_nxt = PH_WAIT;
            end else begin
              pos_nxt = pos_inc;
            end
          end else if (phase_r == PH_WAIT) begin
            timer_nxt = timer_inc;
            retry     = (timer_inc >= timeout_r);
          end
        end
        default: begin
        end
      endcase
      if (retry) begin
        if (att_r >= max_att_r) begin
          phase_nxt     = PH_IDLE;
          out_valid_nxt = 1'b1;
          out_mem_nxt   = 1'b0;
          out_byte_nxt  = 8'd0;
          out_txv_nxt   = 1'b0;
          out_st_nxt    = ST_EXHAUSTED;
          out_att_nxt   = att_r;
        end else begin
          att_nxt   = att_r + 8'd1;
          phase_nxt = PH_SEND;
          pos_nxt   = '0;
          timer_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delims_r  <= '0;
      ack_r     <= '0;
      nack_r    <= '0;
      stop_r    <= '0;
      timeout_r <= TIMEOUT_RESET;
      max_att_r <= MAX_ATT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DELIMS:  delims_r  <= cfg_wdata;
        CFG_ACK:     ack_r     <= cfg_wdata[7:0];
        CFG_NACK:    nack_r    <= cfg_wdata[7:0];
        CFG_STOP:    stop_r    <= cfg_wdata[7:0];
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_MAX_ATT: max_att_r <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pos_r       <= '0;
      att_r       <= '0;
      timer_r     <= '0;
      num_r       <= '0;
      total_r     <= '0;
      crc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      att_r       <= att_nxt;
      timer_r     <= timer_nxt;
      num_r       <= num_nxt;
      total_r     <= total_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_mem_r  <= out_mem_nxt;
    out_byte_r <= out_byte_nxt;
    out_txv_r  <= out_txv_nxt;
    out_st_r   <= out_st_nxt;
    out_att_r  <= out_att_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= req.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rd_r <= mem[mem_ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_att_r, out_st_r, out_txv_r,
                       (out_mem_r ? mem_rd_r : out_byte_r)};

endmodule

// ===== hdl/framed_packet_sender_with_retry.sv =====
// ----------------------------------------------------------------------------
// framed_packet_sender_with_retry
// stop-and-wait frame sender for a byte link, with resend on nack or timeout
// ----------------------------------------------------------------------------
// every request (load payload byte, start packet, received byte, tick) is
// latched and classified by the front end into a two-entry queue; the back
// end retires one request per cycle from that queue unless the output is
// stalled, so with both sides flowing the block sustains one request per
// clock; a result is loaded into the output register at the edge that
// takes its request from the queue, the payload byte of a frame coming
// from the registered read port of the single write / single read payload
// store; a stall on the result side fills the queue and only then drops
// in_tready; configuration writes take effect on the next edge and belong
// to idle periods
// ----------------------------------------------------------------------------
module framed_packet_sender_with_retry
  import fsp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [71:0]           in_tdata,  // data_byte, payload_index, packet_number,
                                           // total_packets, packet_crc, pad
  input  logic [1:0]            in_tuser,  // cmd
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [23:0]           out_tdata, // tx_byte, tx_valid, status, attempt_count, pad
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata
);

  // classified requests between front and back
  logic req_valid;
  logic req_pop;
  req_t req;

  // front: accept and classify, queue of two
  fsp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  // back: frame sequencing, response and timeout handling, output register
  fsp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req_valid),
    .req        (req),
    .req_pop    (req_pop),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
